// File: rtl/kdb_pkg.sv
package kdb_pkg;

    // Item field widths
    localparam int PIN_W       = 6;
    localparam int PIN_IW      = 3;
    localparam int KEY_W       = 3;
    localparam int KIND_W      = 2;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 5;
    localparam int CHG_W       = 8;
    localparam int HELD_W      = 16;
    localparam int OUT_FIELD_W = KEY_W + KIND_W + TIME_W + LEVEL_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_PRESS   = 2'd0;
    localparam logic [1:0] REG_RELEASE = 2'd1;
    localparam logic [1:0] REG_LONG    = 2'd2;

    localparam logic [CHG_W-1:0]  PRESS_TICKS_RST   = 8'd2;
    localparam logic [CHG_W-1:0]  RELEASE_TICKS_RST = 8'd8;
    localparam logic [HELD_W-1:0] LONG_TICKS_RST    = 16'd600;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEB,
        ST_LNG,
        ST_POP,
        ST_RES
    } t_kdb_state;

    typedef struct packed {
        logic [CHG_W-1:0]  press_ticks;
        logic [CHG_W-1:0]  release_ticks;
        logic [HELD_W-1:0] long_ticks;
    } t_kdb_cfg;

    typedef struct packed {
        logic accept;
        logic deb;
        logic lng;
        logic key_adv;
        logic pop_rd;
        logic load_out;
    } t_kdb_cmd;

    typedef struct packed {
        logic last_key;
        logic out_free;
    } t_kdb_sts;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] stamp;
    } t_kdb_event;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] stamp;
        logic [LEVEL_W-1:0] level;
    } t_kdb_result;

endpackage

// File: rtl/kdb_cfg.sv
module kdb_cfg
    import kdb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_kdb_cfg          o_cfg
);

    t_kdb_cfg r_cfg;
    logic     w_wr;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_ticks   <= PRESS_TICKS_RST;
            r_cfg.release_ticks <= RELEASE_TICKS_RST;
            r_cfg.long_ticks    <= LONG_TICKS_RST;
        end else if (w_wr) begin
            case (i_paddr[3:2])
                REG_PRESS:   r_cfg.press_ticks   <= i_pwdata[CHG_W-1:0];
                REG_RELEASE: r_cfg.release_ticks <= i_pwdata[CHG_W-1:0];
                REG_LONG:    r_cfg.long_ticks    <= i_pwdata[HELD_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_PRESS:   o_prdata = APB_DW'(r_cfg.press_ticks);
            REG_RELEASE: o_prdata = APB_DW'(r_cfg.release_ticks);
            REG_LONG:    o_prdata = APB_DW'(r_cfg.long_ticks);
            default:     o_prdata = '0;
        endcase
    end

endmodule

// File: rtl/kdb_ctrl.sv
module kdb_ctrl
    import kdb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_action,
    input  t_kdb_sts i_sts,
    output logic     o_in_ready,
    output t_kdb_cmd o_cmd
);

    t_kdb_state r_state;
    t_kdb_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_action ? ST_POP : ST_DEB;
                end
            end
            ST_DEB: begin
                o_cmd.deb = 1'b1;
                n_state   = ST_LNG;
            end
            ST_LNG: begin
                o_cmd.lng = 1'b1;
                if (i_sts.last_key) begin
                    n_state = ST_RES;
                end else begin
                    o_cmd.key_adv = 1'b1;
                    n_state       = ST_DEB;
                end
            end
            ST_POP: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = ST_RES;
            end
            ST_RES: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/kdb_dp.sv
module kdb_dp
    import kdb_pkg::*;
#(
    parameter int NUM_KEYS    = 6,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_kdb_cmd         i_cmd,
    output t_kdb_sts         o_sts,
    input  logic             i_action,
    input  logic [PIN_W-1:0] i_pins,
    input  t_kdb_cfg         i_cfg,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_kdb_result      o_out
);

    localparam int KW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int LVW = PW + 1;

    // Per-key state
    logic [NUM_KEYS-1:0] r_raw;
    logic [NUM_KEYS-1:0] r_stable;
    logic [NUM_KEYS-1:0] r_long_done;
    logic [CHG_W-1:0]    r_chg_age  [NUM_KEYS];
    logic [HELD_W-1:0]   r_held_age [NUM_KEYS];

    // Item and scan state
    logic [KW-1:0]     r_key;
    logic              r_skip;
    logic              r_is_pop;
    logic [PIN_W-1:0]  r_pins;
    logic [TIME_W-1:0] r_time;

    // Event queue
    t_kdb_event     r_mem [QUEUE_DEPTH];
    t_kdb_event     r_rd_data;
    logic           r_hit;
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;

    t_kdb_result r_out;
    logic        r_out_valid;

    logic [31:0]       w_key32;
    logic              w_now_raw;
    logic              w_changed;
    logic [CHG_W-1:0]  w_age_new;
    logic [HELD_W-1:0] w_held_inc;
    logic              w_pending;
    logic [CHG_W-1:0]  w_need;
    logic              w_flip;
    logic              w_long_fire;
    logic              w_push;
    logic              w_wr_en;
    logic [KIND_W-1:0] w_kind;
    logic [PW-1:0]     w_wr_next;
    logic [PW-1:0]     w_rd_next;
    logic              w_empty;
    logic [LVW-1:0]    w_level;
    logic [31:0]       w_level32;

    assign w_key32   = 32'(r_key);
    assign w_now_raw = (w_key32 < PIN_W) ? ~r_pins[w_key32[PIN_IW-1:0]] : 1'b0;
    assign w_changed = w_now_raw != r_raw[r_key];
    assign w_age_new = w_changed ? '0 :
                       (r_chg_age[r_key] == '1) ? r_chg_age[r_key] : r_chg_age[r_key] + 1'b1;
    assign w_held_inc = (r_held_age[r_key] == '1) ? r_held_age[r_key]
                                                  : r_held_age[r_key] + 1'b1;
    assign w_pending = r_stable[r_key] != w_now_raw;
    assign w_need    = w_now_raw ? i_cfg.press_ticks : i_cfg.release_ticks;
    assign w_flip    = w_pending && (w_age_new >= w_need);

    // held age was updated in the debounce cycle of the same key
    assign w_long_fire = r_stable[r_key] && !r_long_done[r_key] && !r_skip &&
                         (r_held_age[r_key] >= i_cfg.long_ticks);

    assign w_push  = (i_cmd.deb && w_flip) || (i_cmd.lng && w_long_fire);
    assign w_kind  = i_cmd.lng ? KIND_LONG : (w_now_raw ? KIND_PRESS : KIND_RELEASE);

    assign w_wr_next = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign w_rd_next = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign w_empty   = r_rd == r_wr;
    // drop the event silently when the queue is full
    assign w_wr_en   = w_push && (w_wr_next != r_rd);

    assign w_level   = (r_wr >= r_rd) ? LVW'(r_wr) - LVW'(r_rd)
                                      : LVW'(r_wr) + LVW'(QUEUE_DEPTH) - LVW'(r_rd);
    assign w_level32 = 32'(w_level);

    assign o_sts.last_key = w_key32 == 32'(NUM_KEYS - 1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= '{key: w_key32[KEY_W-1:0], kind: w_kind, stamp: r_time};
        end
        if (i_cmd.pop_rd) begin
            r_rd_data <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= '0;
            r_stable    <= '0;
            r_long_done <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_chg_age[k]  <= '0;
                r_held_age[k] <= '0;
            end
            r_key       <= '0;
            r_skip      <= 1'b0;
            r_is_pop    <= 1'b0;
            r_pins      <= '0;
            r_time      <= '0;
            r_hit       <= 1'b0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_is_pop <= i_action;
                r_pins   <= i_pins;
                r_key    <= '0;
                if (!i_action) begin
                    r_time <= r_time + 1'b1;
                end
            end
            if (i_cmd.key_adv) begin
                r_key <= r_key + 1'b1;
            end
            if (i_cmd.deb) begin
                r_raw[r_key]     <= w_now_raw;
                r_chg_age[r_key] <= w_age_new;
                r_skip           <= w_pending && !w_flip;
                if (w_flip) begin
                    r_stable[r_key] <= w_now_raw;
                end
                if (w_flip && w_now_raw) begin
                    r_held_age[r_key]  <= '0;
                    r_long_done[r_key] <= 1'b0;
                end else begin
                    r_held_age[r_key] <= w_held_inc;
                end
            end
            if (i_cmd.lng && w_long_fire) begin
                r_long_done[r_key] <= 1'b1;
            end
            if (w_wr_en) begin
                r_wr <= w_wr_next;
            end
            if (i_cmd.pop_rd) begin
                r_hit <= !w_empty;
                if (!w_empty) begin
                    r_rd <= w_rd_next;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.level <= w_level32[LEVEL_W-1:0];
            if (r_is_pop && r_hit) begin
                r_out.valid <= 1'b1;
                r_out.key   <= r_rd_data.key;
                r_out.kind  <= r_rd_data.kind;
                r_out.stamp <= r_rd_data.stamp;
            end else begin
                r_out.valid <= 1'b0;
                r_out.key   <= '0;
                r_out.kind  <= '0;
                r_out.stamp <= '0;
            end
        end
    end

endmodule

// File: rtl/key_debounce_long_press_events.sv
// Debouncer for NUM_KEYS active-low keys with long-press detection and an event
// queue of QUEUE_DEPTH slots (holding at most QUEUE_DEPTH-1 events; pushes into
// a full queue are dropped). Each input item is either a poll tick (tuser 0,
// pin levels in tdata) or a pop (tuser 1), and gives exactly one result. For a
// tick the scan visits one key at a time, a debounce step then a long-press
// step, each with at most one write into the event store, and then hands the
// result to the output register. A pop reads the store through a register
// before its result is loaded. The next item is accepted in the cycle after
// the result enters the output register, while it still waits to be taken.
// Registers: 0x0 press debounce ticks, 0x4 release debounce ticks, 0x8 long-press
// ticks; write them only while the block is idle.
module key_debounce_long_press_events
    import kdb_pkg::*;
#(
    parameter int NUM_KEYS    = 6,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [5:0] pin_levels
    input  logic                   s_axis_tuser,   // [0] action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] event_key, [4:3] event_kind,
                                                   // [36:5] event_time, [41:37] queue_level
    output logic                   m_axis_tuser,   // [0] event_valid
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_kdb_cfg    w_cfg;
    t_kdb_cmd    w_cmd;
    t_kdb_sts    w_sts;
    t_kdb_result w_out;

    assign pready = 1'b1;

    kdb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    kdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    kdb_dp #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_action    (s_axis_tuser),
        .i_pins      (s_axis_tdata[PIN_W-1:0]),
        .i_cfg       (w_cfg),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_out)
    );

    assign m_axis_tuser = w_out.valid;
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                           w_out.level, w_out.stamp, w_out.kind, w_out.key};

endmodule

// File: rtl/kdb_chk.sv
module kdb_chk
    import kdb_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata,
    input logic                   i_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

    // one item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("item accepted while another is in work");

    // a result without an event carries zero key, kind and time
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser) |-> (i_m_tdata[OUT_FIELD_W-LEVEL_W-1:0] == '0))
        else $error("empty result carries event fields");

    // a returned event has a defined kind
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser) |->
            (i_m_tdata[4:3] == KIND_PRESS || i_m_tdata[4:3] == KIND_RELEASE ||
             i_m_tdata[4:3] == KIND_LONG))
        else $error("event kind out of range");

endmodule

bind key_debounce_long_press_events kdb_chk u_kdb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
